// ===== rtl/sfr_pkg.sv =====
`default_nettype none
package sfr_pkg;

   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 9;
   localparam int ERR_W    = 3;

   localparam logic [BYTE_W-1:0] SYM_SOH = 8'h01;
   localparam logic [BYTE_W-1:0] SYM_STX = 8'h02;
   localparam logic [BYTE_W-1:0] SYM_ETX = 8'h03;
   localparam logic [BYTE_W-1:0] SYM_EOT = 8'h04;
   localparam logic [BYTE_W-1:0] SYM_ENQ = 8'h05;

   // header byte positions after ENQ
   localparam logic [COUNT_W-1:0] HDR_POS_SOH  = 9'd0;
   localparam logic [COUNT_W-1:0] HDR_POS_DEST = 9'd2;
   localparam logic [COUNT_W-1:0] HDR_POS_SRC  = 9'd3;
   localparam logic [COUNT_W-1:0] HDR_POS_FUNC = 9'd4;
   localparam logic [COUNT_W-1:0] HDR_POS_SIZE = 9'd5;
   localparam logic [COUNT_W-1:0] HDR_POS_LAST = 9'd6;

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_HEADER = 7'b0000010,
      PH_STX    = 7'b0000100,
      PH_DATA   = 7'b0001000,
      PH_ETX    = 7'b0010000,
      PH_CKS    = 7'b0100000,
      PH_EOT    = 7'b1000000
   } phase_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_SOH      = 3'd0,
      ERR_HDR_SUM  = 3'd1,
      ERR_DEST     = 3'd2,
      ERR_STX      = 3'd3,
      ERR_ETX      = 3'd4,
      ERR_DATA_SUM = 3'd5,
      ERR_EOT      = 3'd6
   } err_type;

   typedef struct packed {
      logic                send_ack;
      logic                payload_valid;
      logic [BYTE_W-1:0]   payload_byte;
      logic                frame_done;
      logic                frame_good;
      err_type             error_code;
      logic [BYTE_W-1:0]   source_id;
      logic [BYTE_W-1:0]   function_code;
      logic [COUNT_W-1:0]  payload_length;
   } result_type;

   typedef struct packed {
      logic       has_result;
      result_type result;
   } step_type;

endpackage
`default_nettype wire

// ===== rtl/sfr_if.sv =====
`default_nettype none
interface sfr_req_if;
   import sfr_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   import sfr_pkg::*;
   logic               valid;
   logic               ready;
   logic               send_ack;
   logic               payload_valid;
   logic [BYTE_W-1:0]  payload_byte;
   logic               frame_done;
   logic               frame_good;
   logic [ERR_W-1:0]   error_code;
   logic [BYTE_W-1:0]  source_id;
   logic [BYTE_W-1:0]  function_code;
   logic [COUNT_W-1:0] payload_length;

   modport source (output valid, output send_ack, output payload_valid, output payload_byte,
                   output frame_done, output frame_good, output error_code,
                   output source_id, output function_code, output payload_length,
                   input ready);
   modport sink (input valid, input send_ack, input payload_valid, input payload_byte,
                 input frame_done, input frame_good, input error_code,
                 input source_id, input function_code, input payload_length,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/sfr_in_stage.sv =====
`default_nettype none
module sfr_in_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic [sfr_pkg::BYTE_W-1:0] req_byte,
   input  wire logic                      advance,
   output      logic                      in_valid,
   output      logic [sfr_pkg::BYTE_W-1:0] in_byte
);
   import sfr_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              take;

   // accept when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;
endmodule
`default_nettype wire

// ===== rtl/sfr_parser.sv =====
`default_nettype none
module sfr_parser (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [sfr_pkg::BYTE_W-1:0] csr_wr_data,
   input  wire logic                      advance,
   input  wire logic [sfr_pkg::BYTE_W-1:0] in_byte,
   output      sfr_pkg::step_type          step
);
   import sfr_pkg::*;

   logic [BYTE_W-1:0]  node_id_ff;
   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0]  size_ff, size_in;
   logic [BYTE_W-1:0]  src_ff, src_in;
   logic [BYTE_W-1:0]  func_ff, func_in;
   logic [BYTE_W-1:0]  dest_ff, dest_in;
   logic [BYTE_W-1:0]  sum_add;
   result_type         hdr_res;
   result_type         res;
   logic               has;

   assign sum_add = sum_ff + in_byte;

   always_comb begin
      hdr_res                = '0;
      hdr_res.source_id      = src_ff;
      hdr_res.function_code  = func_ff;
      hdr_res.payload_length = {1'b0, size_ff} + 9'd1;
   end

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      size_in  = size_ff;
      src_in   = src_ff;
      func_in  = func_ff;
      dest_in  = dest_ff;
      res      = '0;
      has      = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (in_byte == SYM_ENQ) begin
               phase_in     = PH_HEADER;
               idx_in       = '0;
               sum_in       = '0;
               has          = 1'b1;
               res.send_ack = 1'b1;
            end
         end
         PH_HEADER: begin
            if (idx_ff == HDR_POS_SOH && in_byte != SYM_SOH) begin
               has            = 1'b1;
               res.frame_done = 1'b1;
               res.error_code = ERR_SOH;
               phase_in       = PH_IDLE;
               idx_in         = '0;
            end else begin
               sum_in = sum_add;
               idx_in = idx_ff + 9'd1;
               if (idx_ff == HDR_POS_DEST) dest_in = in_byte;
               if (idx_ff == HDR_POS_SRC)  src_in  = in_byte;
               if (idx_ff == HDR_POS_FUNC) func_in = in_byte;
               if (idx_ff == HDR_POS_SIZE) size_in = in_byte;
               if (idx_ff == HDR_POS_LAST) begin
                  has      = 1'b1;
                  idx_in   = '0;
                  phase_in = PH_IDLE;
                  if (sum_add != '0) begin
                     res.frame_done = 1'b1;
                     res.error_code = ERR_HDR_SUM;
                  end else if (dest_ff != node_id_ff) begin
                     res            = hdr_res;
                     res.frame_done = 1'b1;
                     res.error_code = ERR_DEST;
                  end else begin
                     res          = hdr_res;
                     res.send_ack = 1'b1;
                     phase_in     = PH_STX;
                  end
               end
            end
         end
         PH_STX: begin
            if (in_byte != SYM_STX) begin
               has            = 1'b1;
               res            = hdr_res;
               res.frame_done = 1'b1;
               res.error_code = ERR_STX;
               phase_in       = PH_IDLE;
               idx_in         = '0;
            end else begin
               sum_in   = in_byte;
               idx_in   = '0;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            sum_in = sum_add;
            idx_in = idx_ff + 9'd1;
            // last payload byte when the index reaches size (size + 1 bytes in all)
            if (idx_ff == {1'b0, size_ff}) phase_in = PH_ETX;
            has               = 1'b1;
            res               = hdr_res;
            res.payload_valid = 1'b1;
            res.payload_byte  = in_byte;
         end
         PH_ETX: begin
            if (in_byte != SYM_ETX) begin
               has            = 1'b1;
               res            = hdr_res;
               res.frame_done = 1'b1;
               res.error_code = ERR_ETX;
               phase_in       = PH_IDLE;
               idx_in         = '0;
            end else begin
               sum_in   = sum_add;
               phase_in = PH_CKS;
            end
         end
         PH_CKS: begin
            sum_in = sum_add;
            if (sum_add != '0) begin
               has            = 1'b1;
               res            = hdr_res;
               res.frame_done = 1'b1;
               res.error_code = ERR_DATA_SUM;
               phase_in       = PH_IDLE;
               idx_in         = '0;
            end else begin
               phase_in = PH_EOT;
            end
         end
         PH_EOT: begin
            has      = 1'b1;
            res      = hdr_res;
            phase_in = PH_IDLE;
            idx_in   = '0;
            res.frame_done = 1'b1;
            if (in_byte != SYM_EOT) begin
               res.error_code = ERR_EOT;
            end else begin
               res.send_ack   = 1'b1;
               res.frame_good = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= '0;
         phase_ff   <= PH_IDLE;
         idx_ff     <= '0;
         sum_ff     <= '0;
         size_ff    <= '0;
         src_ff     <= '0;
         func_ff    <= '0;
         dest_ff    <= '0;
      end else begin
         if (csr_wr_en) node_id_ff <= csr_wr_data;
         if (advance) begin
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
            sum_ff   <= sum_in;
            size_ff  <= size_in;
            src_ff   <= src_in;
            func_ff  <= func_in;
            dest_ff  <= dest_in;
         end
      end
   end

   assign step.has_result = has;
   assign step.result     = res;
endmodule
`default_nettype wire

// ===== rtl/sfr_out_stage.sv =====
`default_nettype none
module sfr_out_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire sfr_pkg::step_type  step,
   input  wire logic               rsp_ready,
   output      logic               rsp_valid,
   output      logic               out_free,
   output      sfr_pkg::result_type rsp_result
);
   import sfr_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (advance) begin
         valid_in = step.has_result;
         res_in   = step.result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = res_ff;
endmodule
`default_nettype wire

// ===== rtl/serial_frame_receiver.sv =====
// channel   dir  handshake            payload
// req_chan  in   valid/ready          rx_byte[7:0]
// rsp_chan  out  valid/ready          send_ack, payload_valid, payload_byte, frame_done,
//                                     frame_good, error_code, source_id, function_code,
//                                     payload_length
// csr       in   csr_wr_en            csr_wr_data[7:0] = own node id
//
// One byte per cycle while results are taken: input register, one compare and 8-bit add, result register.
// An accepted byte waits in the input register until it is registered into the result register.
// Synchronous active-high reset returns to waiting for ENQ with node id 0.
// A stalled result holds the input register, so a byte with no result waits as well.
`default_nettype none
module serial_frame_receiver (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [sfr_pkg::BYTE_W-1:0] csr_wr_data,
   sfr_req_if.sink                        req_chan,
   sfr_rsp_if.source                      rsp_chan
);
   import sfr_pkg::*;

   logic              in_valid;
   logic [BYTE_W-1:0] in_byte;
   logic              out_free;
   logic              advance;
   step_type          step;
   result_type        rsp_result;

   // move the held byte through the parser when the result slot is free
   assign advance = in_valid && out_free;

   sfr_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_byte  (req_chan.rx_byte),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_byte   (in_byte)
   );

   sfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .in_byte     (in_byte),
      .step        (step)
   );

   sfr_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .step       (step),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .out_free   (out_free),
      .rsp_result (rsp_result)
   );

   assign rsp_chan.send_ack       = rsp_result.send_ack;
   assign rsp_chan.payload_valid  = rsp_result.payload_valid;
   assign rsp_chan.payload_byte   = rsp_result.payload_byte;
   assign rsp_chan.frame_done     = rsp_result.frame_done;
   assign rsp_chan.frame_good     = rsp_result.frame_good;
   assign rsp_chan.error_code     = rsp_result.error_code;
   assign rsp_chan.source_id      = rsp_result.source_id;
   assign rsp_chan.function_code  = rsp_result.function_code;
   assign rsp_chan.payload_length = rsp_result.payload_length;
endmodule
`default_nettype wire

// ===== rtl/sfr_checker.sv =====
`default_nettype none
module sfr_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       send_ack,
   input wire logic                       payload_valid,
   input wire logic [sfr_pkg::BYTE_W-1:0]  payload_byte,
   input wire logic                       frame_done,
   input wire logic                       frame_good,
   input wire logic [sfr_pkg::ERR_W-1:0]   error_code
);
   import sfr_pkg::*;

   // a stalled item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_byte) &&
                                 $stable(frame_done) && $stable(error_code))
      else $error("stalled item changed");

   a_data_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && payload_valid |-> !frame_done && !send_ack && error_code == ERR_SOH)
      else $error("data item carries an end or ack");

   a_good_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_good |-> frame_done && send_ack && !payload_valid)
      else $error("good frame without end and ack");

   a_bad_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done && !frame_good |-> !send_ack && !payload_valid)
      else $error("failed frame requests ack or data");

   a_no_data_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !payload_valid |-> payload_byte == '0)
      else $error("payload byte set without data");
endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .send_ack      (rsp_chan.send_ack),
   .payload_valid (rsp_chan.payload_valid),
   .payload_byte  (rsp_chan.payload_byte),
   .frame_done    (rsp_chan.frame_done),
   .frame_good    (rsp_chan.frame_good),
   .error_code    (rsp_chan.error_code)
);
`default_nettype wire
